FILE: design/fcg_pkg.sv
// ============================================================================
// fcg_pkg
// Types and constants shared by the four corner gradient pixel design.
// ============================================================================
`default_nettype none

package fcg_pkg;

  localparam int CHANNELS = 3;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 24;
  localparam int FSIDE_W  = 11;
  localparam int COORD_W  = 10;
  localparam int DIFF_W   = 9;   // signed channel difference
  localparam int ADDR_W   = 5;

  // register indexes
  localparam logic [2:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [2:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [2:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [2:0] REG_BOTTOM_RIGHT = 3'd3;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

  localparam logic [FSIDE_W-1:0] WIDTH_RESET  = 11'd80;
  localparam logic [FSIDE_W-1:0] HEIGHT_RESET = 11'd20;

  typedef struct packed {
    logic [COLOR_W-1:0] top_left;
    logic [COLOR_W-1:0] top_right;
    logic [COLOR_W-1:0] bottom_left;
    logic [COLOR_W-1:0] bottom_right;
    logic [FSIDE_W-1:0] frame_width;
    logic [FSIDE_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               in_frame;
  } row_sb_t;

  typedef struct packed {
    logic [COORD_W-1:0]               column;
    logic                             in_frame;
    logic                             last_col;
    logic [CHANNELS-1:0][CHAN_W-1:0]  left;
    logic [CHANNELS-1:0][CHAN_W-1:0]  right;
  } col_sb_t;

  // channel k of a packed color: red first
  function automatic logic [CHAN_W-1:0] chan(input logic [COLOR_W-1:0] color,
                                             input int k);
    chan = color[(CHANNELS-1-k)*CHAN_W +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

FILE: design/fcg_cfg.sv
// ============================================================================
// fcg_cfg
// Register file behind the APB-style configuration port.
// ============================================================================
`default_nettype none

module fcg_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fcg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output fcg_pkg::cfg_t                   cfg
);

  fcg_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[fcg_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.top_left     <= '0;
      cfg_r.top_right    <= '0;
      cfg_r.bottom_left  <= '0;
      cfg_r.bottom_right <= '0;
      cfg_r.frame_width  <= fcg_pkg::WIDTH_RESET;
      cfg_r.frame_height <= fcg_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        fcg_pkg::REG_TOP_LEFT:     cfg_r.top_left     <= pwdata[23:0];
        fcg_pkg::REG_TOP_RIGHT:    cfg_r.top_right    <= pwdata[23:0];
        fcg_pkg::REG_BOTTOM_LEFT:  cfg_r.bottom_left  <= pwdata[23:0];
        fcg_pkg::REG_BOTTOM_RIGHT: cfg_r.bottom_right <= pwdata[23:0];
        fcg_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[10:0];
        fcg_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fcg_pkg::REG_TOP_LEFT:     prdata = {8'd0, cfg_r.top_left};
      fcg_pkg::REG_TOP_RIGHT:    prdata = {8'd0, cfg_r.top_right};
      fcg_pkg::REG_BOTTOM_LEFT:  prdata = {8'd0, cfg_r.bottom_left};
      fcg_pkg::REG_BOTTOM_RIGHT: prdata = {8'd0, cfg_r.bottom_right};
      fcg_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, cfg_r.frame_width};
      fcg_pkg::REG_FRAME_HEIGHT: prdata = {21'd0, cfg_r.frame_height};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/fcg_div.sv
// ============================================================================
// fcg_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero, several lanes sharing one divisor. A zero divisor gives zero.
// ============================================================================
`default_nettype none

module fcg_div #(
  parameter int LANES = 3,
  parameter int DW    = 11,
  parameter int SBW   = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  input  wire logic signed [fcg_pkg::DIFF_W-1:0]    in_num [LANES],
  input  wire logic [DW-1:0]                        divisor,
  input  wire logic [SBW-1:0]                       in_sb,
  output logic                                      out_valid,
  output logic signed [fcg_pkg::DIFF_W-1:0]         out_q [LANES],
  output logic [SBW-1:0]                            out_sb
);

  localparam int NB = fcg_pkg::CHAN_W;

  logic [DW-1:0] rem_r [NB][LANES];
  logic [NB-1:0] a_r   [NB][LANES];
  logic          neg_r [NB][LANES];
  logic          vld_r [NB];
  logic [SBW-1:0] sb_r [NB];

  genvar s, l;
  generate
    for (s = 0; s < NB; s++) begin : g_stage
      for (l = 0; l < LANES; l++) begin : g_lane
        logic [DW-1:0] rem_in;
        logic [NB-1:0] a_in;
        logic          neg_in;
        logic [DW:0]   trial;
        logic [DW-1:0] rem_nxt;
        logic [NB-1:0] a_nxt;
        logic signed [fcg_pkg::DIFF_W-1:0] mag;

        always_comb begin
          mag = in_num[l][fcg_pkg::DIFF_W-1] ? -in_num[l] : in_num[l];
          if (s == 0) begin
            rem_in = '0;
            a_in   = mag[NB-1:0];
            neg_in = in_num[l][fcg_pkg::DIFF_W-1];
          end else begin
            rem_in = rem_r[s-1][l];
            a_in   = a_r[s-1][l];
            neg_in = neg_r[s-1][l];
          end
          trial = {rem_in, a_in[NB-1]};
          if (trial >= {1'b0, divisor}) begin
            rem_nxt = DW'(trial - {1'b0, divisor});
            a_nxt   = {a_in[NB-2:0], 1'b1};
          end else begin
            rem_nxt = trial[DW-1:0];
            a_nxt   = {a_in[NB-2:0], 1'b0};
          end
        end

        always_ff @(posedge clk) begin
          rem_r[s][l] <= rem_nxt;
          a_r[s][l]   <= a_nxt;
          neg_r[s][l] <= neg_in;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= (s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s-1];
        end
      end

      always_ff @(posedge clk) begin
        sb_r[s] <= (s == 0) ? in_sb : sb_r[(s == 0) ? 0 : s-1];
      end
    end
  endgenerate

  // apply sign and register the quotient
  logic signed [fcg_pkg::DIFF_W-1:0] q_r [LANES];
  logic                              qv_r;
  logic [SBW-1:0]                    qsb_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (divisor == '0) begin
        q_r[i] <= '0;
      end else if (neg_r[NB-1][i]) begin
        q_r[i] <= -$signed({1'b0, a_r[NB-1][i]});
      end else begin
        q_r[i] <= $signed({1'b0, a_r[NB-1][i]});
      end
    end
    qsb_r <= sb_r[NB-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= 1'b0;
    end else begin
      qv_r <= vld_r[NB-1];
    end
  end

  assign out_valid = qv_r;
  assign out_q     = q_r;
  assign out_sb    = qsb_r;

endmodule

`default_nettype wire

FILE: design/four_corner_gradient_pixel.sv
// ============================================================================
// four_corner_gradient_pixel
// Four corner color gradient generator: pixel color from row and column.
// ============================================================================
// One request (row, column) is taken every clock; busy is always low. Each
// request yields one result on out_* with out_valid high for exactly one
// cycle, in request order. The receiver cannot stall the block and must take
// every result. The latency is set by two 8-stage bit-per-stage dividers
// (edge step by height - 1, then column step by width - 1) plus the entry,
// multiply and output registers.
// Configure corners and frame size only while no request is in flight.
// ============================================================================
`default_nettype none

module four_corner_gradient_pixel #(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [9:0]                 in_row,
  input  wire logic [9:0]                 in_column,
  // result channel
  output logic                            out_valid,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            out_in_frame,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fcg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  localparam int SIDEW = $clog2(MAX_SIDE + 1);
  localparam int NCH   = fcg_pkg::CHANNELS;
  localparam int RSBW  = $bits(fcg_pkg::row_sb_t);
  localparam int CSBW  = $bits(fcg_pkg::col_sb_t);

  fcg_pkg::cfg_t cfg;

  fcg_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg
  );

  assign busy = 1'b0;

  // saturate frame sides to MAX_SIDE
  logic [SIDEW-1:0] w_sat, h_sat, wd, hd;
  always_comb begin
    if (32'(cfg.frame_width) > 32'(MAX_SIDE)) w_sat = SIDEW'(MAX_SIDE);
    else                                      w_sat = SIDEW'(cfg.frame_width);
    if (32'(cfg.frame_height) > 32'(MAX_SIDE)) h_sat = SIDEW'(MAX_SIDE);
    else                                       h_sat = SIDEW'(cfg.frame_height);
    wd = w_sat - SIDEW'(1);
    hd = h_sat - SIDEW'(1);
  end

  // entry stage: capture the request
  logic [9:0] row_r, col_r;
  logic       v0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start;
  end
  always_ff @(posedge clk) begin
    if (start) begin
      row_r <= in_row;
      col_r <= in_column;
    end
  end

  // edge differences: lanes 0..2 left edge, 3..5 right edge
  fcg_pkg::row_sb_t rsb_in, rsb_out;
  logic signed [fcg_pkg::DIFF_W-1:0] edge_num [2*NCH];
  logic signed [fcg_pkg::DIFF_W-1:0] edge_q   [2*NCH];
  logic [RSBW-1:0] rsb_vec;
  logic            rv;

  always_comb begin
    rsb_in.row      = row_r;
    rsb_in.column   = col_r;
    rsb_in.in_frame = (32'(row_r) < 32'(h_sat)) && (32'(col_r) < 32'(w_sat));
    for (int k = 0; k < NCH; k++) begin
      edge_num[k]     = $signed({1'b0, fcg_pkg::chan(cfg.bottom_left, k)})
                      - $signed({1'b0, fcg_pkg::chan(cfg.top_left, k)});
      edge_num[k+NCH] = $signed({1'b0, fcg_pkg::chan(cfg.bottom_right, k)})
                      - $signed({1'b0, fcg_pkg::chan(cfg.top_right, k)});
    end
  end

  fcg_div #(.LANES(2*NCH), .DW(SIDEW), .SBW(RSBW)) u_row_div (
    .clk, .rst_n,
    .in_valid (v0_r),
    .in_num   (edge_num),
    .divisor  (hd),
    .in_sb    (RSBW'(rsb_in)),
    .out_valid(rv),
    .out_q    (edge_q),
    .out_sb   (rsb_vec)
  );
  assign rsb_out = fcg_pkg::row_sb_t'(rsb_vec);

  // edge values: corner + row * step
  fcg_pkg::col_sb_t csb_r;
  logic             v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= rv;
  end

  always_ff @(posedge clk) begin
    logic signed [20:0] lsum, rsum;
    csb_r.column   <= rsb_out.column;
    csb_r.in_frame <= rsb_out.in_frame;
    csb_r.last_col <= (32'(rsb_out.column) == 32'(wd));
    for (int k = 0; k < NCH; k++) begin
      lsum = $signed({1'b0, rsb_out.row}) * edge_q[k]
           + $signed({13'd0, fcg_pkg::chan(cfg.top_left, k)});
      rsum = $signed({1'b0, rsb_out.row}) * edge_q[k+NCH]
           + $signed({13'd0, fcg_pkg::chan(cfg.top_right, k)});
      csb_r.left[k]  <= lsum[7:0];
      csb_r.right[k] <= rsum[7:0];
    end
  end

  // column step per channel
  logic signed [fcg_pkg::DIFF_W-1:0] col_num [NCH];
  logic signed [fcg_pkg::DIFF_W-1:0] col_q   [NCH];
  logic [CSBW-1:0]  csb_vec;
  fcg_pkg::col_sb_t csb_out;
  logic             cv;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      col_num[k] = $signed({1'b0, csb_r.right[k]}) - $signed({1'b0, csb_r.left[k]});
    end
  end

  fcg_div #(.LANES(NCH), .DW(SIDEW), .SBW(CSBW)) u_col_div (
    .clk, .rst_n,
    .in_valid (v1_r),
    .in_num   (col_num),
    .divisor  (wd),
    .in_sb    (CSBW'(csb_r)),
    .out_valid(cv),
    .out_q    (col_q),
    .out_sb   (csb_vec)
  );
  assign csb_out = fcg_pkg::col_sb_t'(csb_vec);

  // pixel: left + column * step, last column takes the right value exactly
  logic [7:0] px_r [NCH];
  logic       inf_r, ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= cv;
  end

  always_ff @(posedge clk) begin
    logic signed [20:0] p;
    inf_r <= csb_out.in_frame;
    for (int k = 0; k < NCH; k++) begin
      p = $signed({1'b0, csb_out.column}) * col_q[k]
        + $signed({13'd0, csb_out.left[k]});
      if (!csb_out.in_frame)      px_r[k] <= '0;
      else if (csb_out.last_col)  px_r[k] <= csb_out.right[k];
      else if (p < 0)             px_r[k] <= '0;
      else if (p > 21'sd255)      px_r[k] <= 8'd255;
      else                        px_r[k] <= p[7:0];
    end
  end

  assign out_valid    = ov_r;
  assign out_red      = px_r[0];
  assign out_green    = px_r[1];
  assign out_blue     = px_r[2];
  assign out_in_frame = inf_r;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the four corner gradient pixel generator.
// ============================================================================
// Writes corners and frame size through the register port, then sends pixel
// requests in bursts and checks every result against an in-bench gradient
// predictor. Registers change only after all results of a phase are back.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_SIDE   = 1024;
  localparam int LATENCY    = 21;
  localparam int N_PHASES   = 10;
  localparam int N_RANDOM   = 85;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] column;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_frame;
  } pixel_color_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [9:0] in_row;
  logic [9:0] in_column;
  logic out_valid;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic out_in_frame;
  logic psel;
  logic penable;
  logic pwrite;
  logic [fcg_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // configuration shadow, updated when a write completes
  logic [23:0] sh_tl, sh_tr, sh_bl, sh_br;
  logic [10:0] sh_width, sh_height;

  pixel_req_t   pending_reqs[$];
  pixel_color_t expected_colors[$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  burst_left;
  int unsigned  gap_left;

  four_corner_gradient_pixel #(.MAX_SIDE(MAX_SIDE)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_row(in_row), .in_column(in_column),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_in_frame(out_in_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // truncating signed divide; non-positive divisor gives zero step
  function automatic int step_div(input int num, input int den);
    if (den <= 0) return 0;
    return num / den;
  endfunction

  // predict one pixel from the shadow registers
  function automatic pixel_color_t gradient_pixel(input pixel_req_t req);
    pixel_color_t res;
    int w, h, tl, tr, bl, br, left, right, px, r, c;
    w = (int'(sh_width) > MAX_SIDE) ? MAX_SIDE : int'(sh_width);
    h = (int'(sh_height) > MAX_SIDE) ? MAX_SIDE : int'(sh_height);
    r = int'(req.row);
    c = int'(req.column);
    res = '0;
    if (r >= h || c >= w) return res;
    for (int k = 0; k < 3; k++) begin
      tl = int'(sh_tl[(2-k)*8 +: 8]);
      tr = int'(sh_tr[(2-k)*8 +: 8]);
      bl = int'(sh_bl[(2-k)*8 +: 8]);
      br = int'(sh_br[(2-k)*8 +: 8]);
      left  = tl + r * step_div(bl - tl, h - 1);
      right = tr + r * step_div(br - tr, h - 1);
      if (c == w - 1) px = right;
      else px = left + c * step_div(right - left, w - 1);
      if (px < 0) px = 0;
      if (px > 255) px = 255;
      case (k)
        0: res.red = px[7:0];
        1: res.green = px[7:0];
        default: res.blue = px[7:0];
      endcase
    end
    res.in_frame = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] error: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // write one register: setup cycle then access cycle, driven on falling edges
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = fcg_pkg::ADDR_W'({idx, 2'b00}); pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      fcg_pkg::REG_TOP_LEFT:     sh_tl = value[23:0];
      fcg_pkg::REG_TOP_RIGHT:    sh_tr = value[23:0];
      fcg_pkg::REG_BOTTOM_LEFT:  sh_bl = value[23:0];
      fcg_pkg::REG_BOTTOM_RIGHT: sh_br = value[23:0];
      fcg_pkg::REG_FRAME_WIDTH:  sh_width = value[10:0];
      fcg_pkg::REG_FRAME_HEIGHT: sh_height = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic load_frame(input logic [23:0] tl, input logic [23:0] tr,
                            input logic [23:0] bl, input logic [23:0] br,
                            input logic [10:0] w, input logic [10:0] h);
    reg_write(fcg_pkg::REG_TOP_LEFT, {8'h00, tl});
    reg_write(fcg_pkg::REG_TOP_RIGHT, {8'h00, tr});
    reg_write(fcg_pkg::REG_BOTTOM_LEFT, {8'h00, bl});
    reg_write(fcg_pkg::REG_BOTTOM_RIGHT, {8'h00, br});
    reg_write(fcg_pkg::REG_FRAME_WIDTH, {21'd0, w});
    reg_write(fcg_pkg::REG_FRAME_HEIGHT, {21'd0, h});
  endtask

  task automatic queue_pixel(input int r, input int c);
    pixel_req_t req;
    req.row = r[9:0];
    req.column = c[9:0];
    pending_reqs.push_back(req);
  endtask

  // hold until every request is sent and answered, then let the pipe drain
  task automatic drain;
    while (pending_reqs.size() != 0 || expected_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // mostly in-frame pixels with stress on edges, some full-range noise
  task automatic random_pixels(input int n);
    int w, h, r, c;
    w = (int'(sh_width) > MAX_SIDE) ? MAX_SIDE : int'(sh_width);
    h = (int'(sh_height) > MAX_SIDE) ? MAX_SIDE : int'(sh_height);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r = int'($urandom_range(0, 1023));
          c = int'($urandom_range(0, 1023));
        end
        2: begin
          r = (h > 0) ? h - 1 : 0;
          c = (w > 0) ? int'($urandom_range(0, w - 1)) : 0;
        end
        3: begin
          r = (h > 0) ? int'($urandom_range(0, h - 1)) : 0;
          c = (w > 0) ? w - 1 : 0;
        end
        default: begin
          r = (h > 0) ? int'($urandom_range(0, h - 1)) : 0;
          c = (w > 0) ? int'($urandom_range(0, w - 1)) : 0;
        end
      endcase
      queue_pixel(r, c);
    end
  endtask

  // driver: bursts of requests separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_colors.push_back(gradient_pixel(pending_reqs.pop_front()));
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_row <= pending_reqs[0].row;
        in_column <= pending_reqs[0].column;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    pixel_color_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_in_frame !== want.in_frame)
          report_mismatch("in_frame", out_in_frame, want.in_frame);
      end
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_colors.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [10:0] w, h;
    rst_n = 1'b0; start = 1'b0; in_row = '0; in_column = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; results_seen = 0; burst_left = 0; gap_left = 0;
    sh_tl = '0; sh_tr = '0; sh_bl = '0; sh_br = '0;
    sh_width = 11'd80; sh_height = 11'd20;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset frame: all black, 80 x 20; poke corners and outside
    queue_pixel(0, 0); queue_pixel(19, 79); queue_pixel(20, 0); queue_pixel(0, 80);
    drain();

    // directed: saturated opposite corners, falling and rising channels
    load_frame(24'hFF00FF, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 11'd7, 11'd5);
    queue_pixel(0, 0); queue_pixel(0, 6); queue_pixel(4, 0); queue_pixel(4, 6);
    queue_pixel(2, 3); queue_pixel(1, 5); queue_pixel(5, 0); queue_pixel(0, 7);
    queue_pixel(1023, 1023); queue_pixel(1023, 0); queue_pixel(0, 1023);
    drain();

    // directed: largest frame with full-scale edges
    load_frame(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 11'd1024, 11'd1024);
    queue_pixel(0, 0); queue_pixel(1023, 1023); queue_pixel(0, 1023);
    queue_pixel(1023, 0); queue_pixel(512, 511); queue_pixel(341, 682);
    drain();

    // directed: side of one, side of zero, side above the maximum
    load_frame(24'h123456, 24'hABCDEF, 24'hFEDCBA, 24'h654321, 11'd1, 11'd1);
    queue_pixel(0, 0); queue_pixel(0, 1); queue_pixel(1, 0);
    drain();
    reg_write(fcg_pkg::REG_FRAME_WIDTH, 32'd0);
    queue_pixel(0, 0);
    drain();
    reg_write(fcg_pkg::REG_FRAME_WIDTH, 32'h7FF);
    reg_write(fcg_pkg::REG_FRAME_HEIGHT, 32'd2047);
    queue_pixel(0, 1023); queue_pixel(1023, 1023); queue_pixel(1, 1022);
    drain();

    // random phases: minimum, maximum and random frames with random corners
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin w = 11'd2; h = 11'd2; end
        1: begin w = 11'd1024; h = 11'd1024; end
        2: begin
          w = 11'($urandom_range(0, 2047));
          h = 11'($urandom_range(0, 2047));
        end
        default: begin
          w = 11'($urandom_range(2, 64));
          h = 11'($urandom_range(2, 64));
        end
      endcase
      load_frame(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), w, h);
      random_pixels(N_RANDOM);
      drain();
    end

    $display("checked %0d pixel results over %0d random frame settings",
             results_seen, N_PHASES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
